@@ src/mdfa_pkg.sv @@
package mdfa_pkg;

  localparam int STATE_W   = 6;
  localparam int CHAR_W    = 8;
  localparam int ACTION_W  = 2;
  localparam int CHARS_W   = 64;
  localparam int MASK_W    = 8;
  localparam int NUM_CODES = 2 ** STATE_W;

  localparam int DEF_NUM_STATES = 64;
  localparam int DEF_NUM_LANES  = 8;

  localparam logic [ACTION_W-1:0] ACT_TRANS  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ACCEPT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MATCH  = 2'd2;

  typedef logic [STATE_W-1:0] state_t;

  typedef struct packed {
    logic wr_trans;
    logic wr_accept;
    logic match;
    logic emit;
    logic busy;
  } lane_ctl_t;

  typedef struct packed {
    logic step;
    logic ended;
    logic accept;
  } lane_stat_t;

endpackage

@@ src/mdfa_lane.sv @@
module mdfa_lane #(
  parameter int NUM_STATES = mdfa_pkg::DEF_NUM_STATES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mdfa_pkg::lane_ctl_t         ctl,
  input  mdfa_pkg::state_t            root,
  input  mdfa_pkg::state_t            tbl_state,
  input  logic [mdfa_pkg::CHAR_W-1:0] tbl_char,
  input  mdfa_pkg::state_t            tbl_value,
  input  logic [mdfa_pkg::CHAR_W-1:0] lane_byte,
  output mdfa_pkg::lane_stat_t        stat
);

  localparam int IDXW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int ADDRW = IDXW + mdfa_pkg::CHAR_W;
  localparam int DEPTH = NUM_STATES * (2 ** mdfa_pkg::CHAR_W);

  function automatic logic [mdfa_pkg::NUM_CODES*IDXW-1:0] build_mod_lut();
    logic [mdfa_pkg::NUM_CODES*IDXW-1:0] lut;
    lut = '0;
    for (int i = 0; i < mdfa_pkg::NUM_CODES; i++) begin
      lut[i*IDXW +: IDXW] = IDXW'(i % NUM_STATES);
    end
    return lut;
  endfunction

  localparam logic [mdfa_pkg::NUM_CODES*IDXW-1:0] MOD_LUT = build_mod_lut();

  mdfa_pkg::state_t trans_mem [DEPTH];
  logic             accept_mem [NUM_STATES];

  mdfa_pkg::state_t rd_state;
  mdfa_pkg::state_t hold_state;
  mdfa_pkg::state_t lookup_state;
  logic             fresh;
  logic             ended;
  logic             accept_rd;
  logic             ended_eff;
  logic             step;
  logic [IDXW-1:0]  cur_idx;
  logic [IDXW-1:0]  wr_idx;
  logic [ADDRW-1:0] rd_addr;
  logic [ADDRW-1:0] wr_addr;

  assign ended_eff    = ctl.busy & ended;
  assign step         = ctl.match & ~ended_eff & (lane_byte != '0);
  assign lookup_state = !ctl.busy ? root : (fresh ? rd_state : hold_state);
  assign cur_idx      = MOD_LUT[int'(lookup_state)*IDXW +: IDXW];
  assign wr_idx       = MOD_LUT[int'(tbl_state)*IDXW +: IDXW];
  assign rd_addr      = {cur_idx, lane_byte};
  assign wr_addr      = {wr_idx, tbl_char};

  always_ff @(posedge clk) begin
    if (ctl.wr_trans) begin
      trans_mem[wr_addr] <= tbl_value;
    end
    if (step) begin
      rd_state <= trans_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_accept) begin
      accept_mem[wr_idx] <= tbl_value[0];
    end
    if (ctl.emit) begin
      accept_rd <= accept_mem[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    hold_state <= lookup_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b0;
      ended <= 1'b0;
    end else begin
      fresh <= step;
      if (ctl.match) begin
        ended <= ctl.emit ? 1'b0 : (ended_eff | (lane_byte == '0));
      end
    end
  end

  assign stat.step   = step;
  assign stat.ended  = ended;
  assign stat.accept = accept_rd;

endmodule

@@ src/mdfa_merge.sv @@
module mdfa_merge #(
  parameter int NUM_LANES = mdfa_pkg::DEF_NUM_LANES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        emit,
  input  logic [NUM_LANES-1:0]        lane_accept,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [mdfa_pkg::MASK_W-1:0] match_mask,
  output logic                        space
);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int CNTW   = QAW + 1;

  logic [mdfa_pkg::MASK_W-1:0] queue [QDEPTH];
  logic [QAW-1:0]              wr_ptr;
  logic [QAW-1:0]              rd_ptr;
  logic [CNTW-1:0]             count;
  logic [CNTW-1:0]             count_next;
  logic                        pending;
  logic                        push;
  logic                        pop;

  assign push = pending;
  assign pop  = out_valid & out_ready;

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= mdfa_pkg::MASK_W'(lane_accept);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
    end else begin
      pending <= emit;
      count   <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  assign out_valid  = (count != '0);
  assign match_mask = queue[rd_ptr];
  assign space      = ((count + CNTW'(pending)) <= CNTW'(QDEPTH - 2));

endmodule

@@ src/multilane_dfa_table_matcher_core.sv @@
// A match word that ends the batch registers each lane's accept bit and a pending flag,
// then writes the mask into the result queue, from which it leaves once out_ready is high.
// Throughput: one word per cycle; each lane's table read feeds its next lookup address.
// Input stalls once three masks sit in the result queue or wait to enter it.
// Reset: clears control state and the result queue, lanes restart at root state 0;
// tables stay undefined until loaded.
module multilane_dfa_table_matcher_core #(
  parameter int NUM_STATES = mdfa_pkg::DEF_NUM_STATES,
  parameter int NUM_LANES  = mdfa_pkg::DEF_NUM_LANES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mdfa_pkg::STATE_W-1:0]  start_state,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mdfa_pkg::ACTION_W-1:0] action,
  input  logic [mdfa_pkg::STATE_W-1:0]  table_state,
  input  logic [mdfa_pkg::CHAR_W-1:0]   table_char,
  input  logic [mdfa_pkg::STATE_W-1:0]  table_value,
  input  logic [mdfa_pkg::CHARS_W-1:0]  lane_chars,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mdfa_pkg::MASK_W-1:0]   match_mask
);

  mdfa_pkg::state_t     root;
  logic                 busy;
  logic                 in_acc;
  logic                 match;
  logic                 emit;
  logic                 space;
  mdfa_pkg::lane_ctl_t  ctl;
  mdfa_pkg::lane_stat_t stat [NUM_LANES];
  logic [NUM_LANES-1:0] step;
  logic [NUM_LANES-1:0] ended;
  logic [NUM_LANES-1:0] lane_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign in_acc    = in_valid & in_ready;
  assign match     = in_acc & (action == mdfa_pkg::ACT_MATCH);
  assign emit      = match & ~(|step);

  assign ctl.wr_trans  = in_acc & (action == mdfa_pkg::ACT_TRANS);
  assign ctl.wr_accept = in_acc & (action == mdfa_pkg::ACT_ACCEPT);
  assign ctl.match     = match;
  assign ctl.emit      = emit;
  assign ctl.busy      = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
      busy <= 1'b0;
    end else begin
      if (cfg_valid) begin
        root <= start_state;
      end
      if (match) begin
        busy <= ~emit;
      end
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    mdfa_lane #(
      .NUM_STATES(NUM_STATES)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .root      (root),
      .tbl_state (table_state),
      .tbl_char  (table_char),
      .tbl_value (table_value),
      .lane_byte (lane_chars[i*mdfa_pkg::CHAR_W +: mdfa_pkg::CHAR_W]),
      .stat      (stat[i])
    );
    assign step[i]        = stat[i].step;
    assign ended[i]       = stat[i].ended;
    assign lane_accept[i] = stat[i].accept;
  end

  mdfa_merge #(
    .NUM_LANES(NUM_LANES)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .emit        (emit),
    .lane_accept (lane_accept),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .match_mask  (match_mask),
    .space       (space)
  );

  a_emit_clears_busy: assert property (@(posedge clk) disable iff (rst)
    emit |=> !busy)
    else $error("batch still busy after result");

  a_emit_no_step: assert property (@(posedge clk) disable iff (rst)
    !(emit && (|step)))
    else $error("result raised while a lane stepped");

  a_idle_lanes_clear: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (ended == '0))
    else $error("lane marked ended outside a batch");

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

@@ test/multilane_dfa_table_matcher_core_test.sv @@
`timescale 1ns / 100ps

module multilane_dfa_table_matcher_core_test;

  localparam int LANES = mdfa_pkg::DEF_NUM_LANES;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int ROWS = 21;
  localparam logic [mdfa_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef logic [mdfa_pkg::CHAR_W-1:0] char_t;

  typedef struct packed {
    logic [mdfa_pkg::ACTION_W-1:0] act;
    mdfa_pkg::state_t              st;
    char_t                         ch;
    mdfa_pkg::state_t              val;
    logic [mdfa_pkg::CHARS_W-1:0]  chars;
  } word_t;

  typedef struct packed {
    logic [mdfa_pkg::ACTION_W-1:0] act;
    mdfa_pkg::state_t              st;
    char_t                         ch;
    mdfa_pkg::state_t              val;
    logic [mdfa_pkg::CHARS_W-1:0]  chars;
    logic                          typed;
    logic [mdfa_pkg::MASK_W-1:0]   mask;
  } row_t;

  localparam row_t SCRIPT [ROWS] = '{
    '{mdfa_pkg::ACT_ACCEPT, 6'd0,  8'h00, 6'h01, 64'h0,                   1'b0, 8'h00},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'h0,                   1'b1, 8'hFF},
    '{mdfa_pkg::ACT_ACCEPT, 6'd63, 8'hFF, 6'h3E, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00},
    '{mdfa_pkg::ACT_TRANS,  6'd0,  8'hFF, 6'h3F, 64'h0,                   1'b0, 8'h00},
    '{mdfa_pkg::ACT_TRANS,  6'd63, 8'hFF, 6'h3F, 64'h0,                   1'b0, 8'h00},
    '{mdfa_pkg::ACT_TRANS,  6'd0,  8'h01, 6'h00, 64'h0,                   1'b0, 8'h00},
    '{mdfa_pkg::ACT_TRANS,  6'd0,  8'h00, 6'h3F, 64'h0,                   1'b0, 8'h00},
    '{ACT_NONE,             6'd63, 8'hFF, 6'h3F, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'h0000_0000_0000_FFFF, 1'b0, 8'h00},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'hFFFF_FFFF_FFFF_00FF, 1'b0, 8'h00},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'hFFFF_FFFF_FFFF_FF00, 1'b1, 8'hFC},
    '{mdfa_pkg::ACT_ACCEPT, 6'd63, 8'h00, 6'h01, 64'h0,                   1'b0, 8'h00},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'hFF01_FF01_FF01_FF01, 1'b0, 8'h00},
    '{mdfa_pkg::ACT_ACCEPT, 6'd0,  8'h00, 6'h00, 64'h0,                   1'b0, 8'h00},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'h0,                   1'b1, 8'hAA},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'h0000_0000_0000_00FF, 1'b0, 8'h00},
    '{mdfa_pkg::ACT_TRANS,  6'd63, 8'h80, 6'h2A, 64'h0,                   1'b0, 8'h00},
    '{mdfa_pkg::ACT_ACCEPT, 6'd42, 8'h00, 6'h01, 64'h0,                   1'b0, 8'h00},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'h0000_0000_0000_0080, 1'b0, 8'h00},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'h0,                   1'b1, 8'h01},
    '{mdfa_pkg::ACT_MATCH,  6'd0,  8'h00, 6'h00, 64'h0000_0000_0000_00FF, 1'b0, 8'h00}
  };

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  mdfa_pkg::state_t              start_state;
  logic                          in_valid;
  logic                          in_ready;
  logic [mdfa_pkg::ACTION_W-1:0] action;
  mdfa_pkg::state_t              table_state;
  char_t                         table_char;
  mdfa_pkg::state_t              table_value;
  logic [mdfa_pkg::CHARS_W-1:0]  lane_chars;
  logic                          out_valid;
  logic                          out_ready;
  logic [mdfa_pkg::MASK_W-1:0]   match_mask;

  logic                          row_typed;
  logic [mdfa_pkg::MASK_W-1:0]   row_mask;

  mdfa_pkg::state_t              next_tbl [mdfa_pkg::NUM_CODES * 256];
  bit                            next_known [mdfa_pkg::NUM_CODES * 256];
  char_t                         chars_known [mdfa_pkg::NUM_CODES][$];
  logic                          accept_tbl [mdfa_pkg::NUM_CODES];
  bit                            accept_known [mdfa_pkg::NUM_CODES];
  mdfa_pkg::state_t              lane_st [LANES];
  bit                            lane_done [LANES];
  bit                            batch_on;
  mdfa_pkg::state_t              root_copy;

  logic [mdfa_pkg::MASK_W-1:0]   masks_due [$];
  int                            fail_count = 0;
  int                            quiet_cycles = 0;
  int                            send_idle_pct = 36;
  int                            recv_idle_pct = 78;
  int                            hold_asks = 0;

  multilane_dfa_table_matcher_core u_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .start_state, .in_valid, .in_ready, .action,
    .table_state, .table_char, .table_value, .lane_chars, .out_valid, .out_ready,
    .match_mask
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void step_matcher(input word_t w, output bit emit,
                                       output logic [mdfa_pkg::MASK_W-1:0] mask);
    int idx;
    bit all_done;
    char_t b;
    emit = 1'b0;
    mask = '0;
    case (w.act)
      mdfa_pkg::ACT_TRANS: begin
        idx = int'({w.st, w.ch});
        if (!next_known[idx] && w.ch != 8'h00) chars_known[w.st].push_back(w.ch);
        next_known[idx] = 1'b1;
        next_tbl[idx] = w.val;
      end
      mdfa_pkg::ACT_ACCEPT: begin
        accept_tbl[w.st] = w.val[0];
        accept_known[w.st] = 1'b1;
      end
      mdfa_pkg::ACT_MATCH: begin
        if (!batch_on) begin
          for (int l = 0; l < LANES; l++) begin
            lane_st[l] = root_copy;
            lane_done[l] = 1'b0;
          end
          batch_on = 1'b1;
        end
        all_done = 1'b1;
        for (int l = 0; l < LANES; l++) begin
          if (lane_done[l]) continue;
          b = w.chars[8*l +: 8];
          if (b == 8'h00) begin
            lane_done[l] = 1'b1;
          end else begin
            lane_st[l] = next_tbl[{lane_st[l], b}];
            all_done = 1'b0;
          end
        end
        if (all_done) begin
          for (int l = 0; l < LANES; l++) mask[l] = accept_tbl[lane_st[l]];
          emit = 1'b1;
          batch_on = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // steer running lanes along written entries only; close_all ends the batch unless a lane's accept entry is unwritten
  function automatic word_t plan_word(input bit close_all);
    word_t w;
    mdfa_pkg::state_t at [LANES];
    bit all_end;
    int pick;
    int n;
    w.act = mdfa_pkg::ACT_MATCH;
    w.st = mdfa_pkg::state_t'($urandom);
    w.ch = char_t'($urandom);
    w.val = mdfa_pkg::state_t'($urandom);
    w.chars = {$urandom, $urandom};
    pick = close_all ? 99 : int'($urandom_range(99));
    if (pick < 4) begin
      w.act = ACT_NONE;
      return w;
    end
    if (pick < 12) begin
      w.act = mdfa_pkg::ACT_ACCEPT;
      return w;
    end
    if (pick < 22) begin
      w.act = mdfa_pkg::ACT_TRANS;
      return w;
    end
    all_end = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      at[l] = batch_on ? lane_st[l] : root_copy;
      if (batch_on && lane_done[l]) continue;
      n = chars_known[at[l]].size();
      if (close_all || n == 0 || $urandom_range(99) < 25) begin
        if (!close_all && n == 0 && $urandom_range(1) == 1) begin
          w.act = mdfa_pkg::ACT_TRANS;
          w.st = at[l];
          w.ch = char_t'($urandom_range(255, 1));
          return w;
        end
        w.chars[8*l +: 8] = 8'h00;
      end else begin
        w.chars[8*l +: 8] = chars_known[at[l]][$urandom_range(n - 1)];
        all_end = 1'b0;
      end
    end
    if (all_end) begin
      for (int l = 0; l < LANES; l++) begin
        if (!accept_known[at[l]]) begin
          w.act = mdfa_pkg::ACT_ACCEPT;
          w.st = at[l];
          return w;
        end
      end
    end
    return w;
  endfunction

  always @(posedge clk) begin
    word_t w;
    bit got;
    logic [mdfa_pkg::MASK_W-1:0] m;
    if (!rst) begin
      if (cfg_valid && cfg_ready) root_copy = start_state;
      if (in_valid && in_ready) begin
        w = '{action, table_state, table_char, table_value, lane_chars};
        step_matcher(w, got, m);
        if (row_typed) masks_due.push_back(row_mask);
        else if (got) masks_due.push_back(m);
      end
      if (out_valid && out_ready) begin
        if (masks_due.size() == 0) begin
          $display("%0t: match_mask expected none, got %h", $time, match_mask);
          fail_count++;
        end else begin
          m = masks_due.pop_front();
          if (match_mask !== m) begin
            $display("%0t: match_mask expected %h, got %h", $time, m, match_mask);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input word_t w, input bit typed,
                           input logic [mdfa_pkg::MASK_W-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action = w.act;
    table_state = w.st;
    table_char = w.ch;
    table_value = w.val;
    lane_chars = w.chars;
    row_typed = typed;
    row_mask = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid = 1'b0;
    while (masks_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_root(input mdfa_pkg::state_t v);
    wait_results();
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    start_state = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_results();
      send_word(plan_word(1'b0), 1'b0, 8'h00);
    end
  endtask

  initial begin
    word_t w;
    rst = 1'b1;
    cfg_valid = 1'b0;
    start_state = '0;
    in_valid = 1'b0;
    action = ACT_NONE;
    table_state = '0;
    table_char = '0;
    table_value = '0;
    lane_chars = '0;
    row_typed = 1'b0;
    row_mask = '0;
    root_copy = '0;
    batch_on = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < ROWS; r++) begin
      w = '{SCRIPT[r].act, SCRIPT[r].st, SCRIPT[r].ch, SCRIPT[r].val, SCRIPT[r].chars};
      send_word(w, SCRIPT[r].typed, SCRIPT[r].mask);
    end
    // the batch is still open here, so the new root waits for the next one
    write_root(6'd63);
    run_random(240);

    send_idle_pct = 78;
    recv_idle_pct = 36;
    write_root(mdfa_pkg::state_t'($urandom_range(62, 1)));
    run_random(240);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_root(6'd0);
    hold_asks++;
    repeat (12) send_word(plan_word(1'b1), 1'b0, 8'h00);
    run_random(240);

    wait_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mdfa_pkg.sv
src/mdfa_lane.sv
src/mdfa_merge.sv
src/multilane_dfa_table_matcher_core.sv
test/multilane_dfa_table_matcher_core_test.sv
